[rtl/bdc_pkg.sv]
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the button debounce block
// Request and result payload layouts, configuration register set and the
// register indexes of the configuration port.
// ----------------------------------------------------------------------------
package bdc_pkg;

   // Width of each configuration register and of the port's write data.
   localparam int CFG_WIDTH = 16;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_DEBOUNCE_TICKS = 1'b0,
      CSR_WINDOW_TICKS   = 1'b1
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [CFG_WIDTH-1:0] WINDOW_RESET   = 16'd1000;

   // One request: a sampled button level and a clear strobe.
   typedef struct packed {
      logic pressed_level;
      logic clear_double;
   } req_payload_type;

   // One result.
   typedef struct packed {
      logic pressed_now;
      logic held;
      logic double_seen;
      logic active_state;
   } rsp_payload_type;

   // Configuration register set.
   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] window_ticks;
   } cfg_type;

endpackage

[rtl/bdc_core.sv]
// ----------------------------------------------------------------------------
// bdc_core: debounce, double-click and hold state update
// Holds the timers and flags and computes one result per request in a
// single pass of combinational logic; the state advances when step is high.
// ----------------------------------------------------------------------------
module bdc_core
   import bdc_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type req_data,
   input  cfg_type         cfg,
   output rsp_payload_type rsp_data
);

   localparam int LOAD_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   // Timer load value: zero acts as one, lengths beyond the counter saturate.
   function automatic logic [COUNT_WIDTH-1:0] load_value(input logic [CFG_WIDTH-1:0] ticks);
      logic [LOAD_WIDTH-1:0] ext;
      logic [LOAD_WIDTH-1:0] lim;
      ext = LOAD_WIDTH'(ticks);
      lim = LOAD_WIDTH'({COUNT_WIDTH{1'b1}});
      if (ext == '0) begin
         ext = LOAD_WIDTH'(1);
      end
      if (ext > lim) begin
         ext = lim;
      end
      return ext[COUNT_WIDTH-1:0];
   endfunction

   logic                   last_level_ff,  last_level_in;
   logic [COUNT_WIDTH-1:0] db_count_ff,    db_count_in;
   logic                   db_running_ff,  db_running_in;
   logic                   db_target_ff,   db_target_in;
   logic [COUNT_WIDTH-1:0] win_count_ff,   win_count_in;
   logic                   win_running_ff, win_running_in;
   logic                   first_click_ff, first_click_in;
   logic                   active_ff,      active_in;
   logic                   double_ff,      double_in;
   logic                   hold_ff,        hold_in;

   logic                   db_expire;
   logic                   win_expire;
   logic [COUNT_WIDTH-1:0] win_count_mid;
   logic                   win_running_mid;
   logic                   first_mid;
   logic                   double_mid;
   logic                   pressed;

   // Next-state logic: debounce expiry, then window expiry, then edge handling.
   always_comb begin
      pressed         = req_data.pressed_level;
      last_level_in   = req_data.pressed_level;
      db_count_in     = db_count_ff;
      db_running_in   = db_running_ff;
      db_target_in    = db_target_ff;
      active_in       = active_ff;
      hold_in         = hold_ff;
      first_mid       = first_click_ff;
      double_mid      = double_ff;
      win_count_mid   = win_count_ff;
      win_running_mid = win_running_ff;

      // Debounce countdown.
      db_expire = db_running_ff && (db_count_ff <= COUNT_WIDTH'(1));
      if (db_running_ff) begin
         db_count_in = db_expire ? '0 : db_count_ff - COUNT_WIDTH'(1);
      end
      if (db_expire) begin
         db_running_in = 1'b0;
         if (pressed) begin
            if (db_target_ff) begin
               active_in       = ~active_ff;
               first_mid       = 1'b0;
               double_mid      = 1'b1;
               win_running_mid = 1'b0;
               win_count_mid   = '0;
            end else begin
               first_mid = ~first_click_ff;
            end
         end
      end

      // Double-click window countdown.
      win_count_in   = win_count_mid;
      win_running_in = win_running_mid;
      first_click_in = first_mid;
      win_expire = win_running_mid && (win_count_mid <= COUNT_WIDTH'(1));
      if (win_running_mid) begin
         win_count_in = win_expire ? '0 : win_count_mid - COUNT_WIDTH'(1);
      end
      if (win_expire) begin
         win_running_in = 1'b0;
         first_click_in = 1'b0;
         hold_in        = 1'b1;
      end

      // Level change restarts the debounce and possibly the window.
      if (req_data.pressed_level != last_level_ff) begin
         hold_in       = 1'b0;
         db_count_in   = load_value(cfg.debounce_ticks);
         db_running_in = 1'b1;
         if (first_click_in) begin
            db_target_in = 1'b1;
         end else begin
            db_target_in   = 1'b0;
            win_count_in   = load_value(cfg.window_ticks);
            win_running_in = 1'b1;
         end
      end

      rsp_data.pressed_now  = pressed;
      rsp_data.held         = pressed & hold_in;
      rsp_data.double_seen  = double_mid;
      rsp_data.active_state = active_in;

      // The clear strobe acts after the result is formed.
      double_in = double_mid & ~req_data.clear_double;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff  <= 1'b0;
         db_count_ff    <= '0;
         db_running_ff  <= 1'b0;
         db_target_ff   <= 1'b0;
         win_count_ff   <= '0;
         win_running_ff <= 1'b0;
         first_click_ff <= 1'b0;
         active_ff      <= 1'b0;
         double_ff      <= 1'b0;
         hold_ff        <= 1'b0;
      end else if (step) begin
         last_level_ff  <= last_level_in;
         db_count_ff    <= db_count_in;
         db_running_ff  <= db_running_in;
         db_target_ff   <= db_target_in;
         win_count_ff   <= win_count_in;
         win_running_ff <= win_running_in;
         first_click_ff <= first_click_in;
         active_ff      <= active_in;
         double_ff      <= double_in;
         hold_ff        <= hold_in;
      end
   end

   // A timer runs exactly while its count is non-zero.
   a_db_run_count: assert property (@(posedge clock) disable iff (reset)
      db_running_ff == (db_count_ff != '0))
      else $error("debounce running flag disagrees with its count");

   a_win_run_count: assert property (@(posedge clock) disable iff (reset)
      win_running_ff == (win_count_ff != '0))
      else $error("window running flag disagrees with its count");

   // Hold is set only when the window has ended, and any restart clears it.
   a_hold_no_window: assert property (@(posedge clock) disable iff (reset)
      !(hold_ff && win_running_ff))
      else $error("hold flag set while the window is running");

endmodule

[rtl/bdc_out_stage.sv]
// ----------------------------------------------------------------------------
// bdc_out_stage: result register
// Holds one result until it is taken, and reports when it can be reloaded.
// ----------------------------------------------------------------------------
module bdc_out_stage
   import bdc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  rsp_payload_type load_data,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   // The register frees up in the same cycle its result is taken.
   assign can_load  = ~valid_ff | rsp_ready;
   assign valid_in  = load | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset needed.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

[rtl/button_debounce_double_click_hold.sv]
// ----------------------------------------------------------------------------
// button_debounce_double_click_hold: debounced button with click detection
// Debounces a sampled button level, detects double clicks (toggling an
// active flag) and long presses, with programmable debounce and window.
//
//   Channel  Ports                              Carries
//   req      req_valid/req_ready/req_payload    sampled level, clear strobe
//   rsp      rsp_valid/rsp_ready/rsp_payload    pressed, held, double, active
//   csr      csr_write_en/csr_index/csr_wdata   debounce and window lengths
//
// One request per cycle sustained while rsp_ready stays high; an accepted
// request passes through the input register, then the result register,
// before rsp_valid rises.
// Reset is synchronous: it clears all flags and timers and restores the
// lengths to 50 and 1000 ticks.
// While rsp_ready is low the result is held; one more request is taken into
// the input register, after which req_ready drops.
// ----------------------------------------------------------------------------
module button_debounce_double_click_hold
   import bdc_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_write_en,
   input  csr_index_type        csr_index,
   input  logic [CFG_WIDTH-1:0] csr_wdata
);

   cfg_type         cfg_ff;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic            can_load;
   logic            advance;
   rsp_payload_type step_result;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.window_ticks   <= WINDOW_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: cfg_ff.debounce_ticks <= csr_wdata;
            CSR_WINDOW_TICKS:   cfg_ff.window_ticks   <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // Input register: the request moves on whenever the result register frees.
   assign advance     = in_valid_ff & can_load;
   assign req_ready   = ~in_valid_ff | can_load;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~can_load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   bdc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_data (in_data_ff),
      .cfg      (cfg_ff),
      .rsp_data (step_result)
   );

   bdc_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .load_data   (step_result),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[tb/sv/button_debounce_double_click_hold_checker.sv]
// ----------------------------------------------------------------------------
// button_debounce_double_click_hold_checker: result predictor and scoreboard
// Watches the request, result and configuration ports of the debounced
// button block. It keeps its own copy of the timers, click flags and lengths,
// predicts the status for every accepted request and compares each accepted
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module button_debounce_double_click_hold_checker
   import bdc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_payload_type      req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_payload_type      rsp_payload,
   input  logic                 csr_write_en,
   input  csr_index_type        csr_index,
   input  logic [CFG_WIDTH-1:0] csr_wdata,
   output int                   failures,
   output int                   pending
);

   localparam int COUNT_WIDTH = 16;
   localparam logic [31:0] COUNT_LIMIT = 32'((64'd1 << COUNT_WIDTH) - 1);

   // Programmed lengths as the block should hold them.
   logic [CFG_WIDTH-1:0]   debounce_len;
   logic [CFG_WIDTH-1:0]   window_len;

   // Predicted button state.
   logic                   level_prev;
   logic [COUNT_WIDTH-1:0] settle_count;
   logic                   settle_busy;
   logic                   settle_on_active;
   logic [COUNT_WIDTH-1:0] window_count;
   logic                   window_busy;
   logic                   first_click;
   logic                   active_flag;
   logic                   double_flag;
   logic                   hold_flag;

   // Statuses predicted for requests whose results have not arrived yet.
   rsp_payload_type        expected_status[$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   // A length of zero counts as one; anything beyond the counter saturates.
   function automatic logic [COUNT_WIDTH-1:0] timer_load(input logic [CFG_WIDTH-1:0] ticks);
      if (ticks == '0) begin
         return COUNT_WIDTH'(1);
      end
      if (32'(ticks) > COUNT_LIMIT) begin
         return COUNT_LIMIT[COUNT_WIDTH-1:0];
      end
      return COUNT_WIDTH'(ticks);
   endfunction

   // Advances the button state by one sampled level and returns its status.
   function automatic rsp_payload_type next_button_status(input req_payload_type sample);
      rsp_payload_type status;
      logic            level;

      level = sample.pressed_level;

      // The debounce timer is served before the window timer.
      if (settle_busy) begin
         if (settle_count <= COUNT_WIDTH'(1)) begin
            settle_count = '0;
            settle_busy  = 1'b0;
            if (level) begin
               if (settle_on_active) begin
                  active_flag  = ~active_flag;
                  first_click  = 1'b0;
                  double_flag  = 1'b1;
                  window_busy  = 1'b0;
                  window_count = '0;
               end else begin
                  first_click = ~first_click;
               end
            end
         end else begin
            settle_count = settle_count - 1'b1;
         end
      end

      // Window expiry ends a pending first click and marks a long press.
      if (window_busy) begin
         if (window_count <= COUNT_WIDTH'(1)) begin
            window_count = '0;
            window_busy  = 1'b0;
            first_click  = 1'b0;
            hold_flag    = 1'b1;
         end else begin
            window_count = window_count - 1'b1;
         end
      end

      // An edge restarts the debounce timer, and the window on a first click.
      if (level != level_prev) begin
         hold_flag    = 1'b0;
         settle_count = timer_load(debounce_len);
         settle_busy  = 1'b1;
         if (first_click) begin
            settle_on_active = 1'b1;
         end else begin
            settle_on_active = 1'b0;
            window_count     = timer_load(window_len);
            window_busy      = 1'b1;
         end
      end
      level_prev = level;

      status.pressed_now  = level;
      status.held         = level & hold_flag;
      status.double_seen  = double_flag;
      status.active_state = active_flag;

      // The clear strobe acts only after the status has been taken.
      if (sample.clear_double) begin
         double_flag = 1'b0;
      end
      return status;
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         failures++;
         $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
      end
   endtask

   // Configuration, result comparison and prediction, all at the clock edge.
   always @(posedge clock) begin
      rsp_payload_type want;

      if (reset) begin
         debounce_len     = DEBOUNCE_RESET;
         window_len       = WINDOW_RESET;
         level_prev       = 1'b0;
         settle_count     = '0;
         settle_busy      = 1'b0;
         settle_on_active = 1'b0;
         window_count     = '0;
         window_busy      = 1'b0;
         first_click      = 1'b0;
         active_flag      = 1'b0;
         double_flag      = 1'b0;
         hold_flag        = 1'b0;
         expected_status.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DEBOUNCE_TICKS: begin
                  debounce_len = csr_wdata;
               end
               CSR_WINDOW_TICKS: begin
                  window_len = csr_wdata;
               end
               default: begin
               end
            endcase
         end

         // A result can never belong to a request accepted at this same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               failures++;
               $display("%0t: result with no request outstanding, expected none, actual %b",
                        $time, rsp_payload);
            end else begin
               want = expected_status.pop_front();
               check_field("pressed_now", want.pressed_now, rsp_payload.pressed_now);
               check_field("held", want.held, rsp_payload.held);
               check_field("double_seen", want.double_seen, rsp_payload.double_seen);
               check_field("active_state", want.active_state, rsp_payload.active_state);
            end
         end

         if (req_valid && req_ready) begin
            expected_status.push_back(next_button_status(req_payload));
         end
      end
      pending = expected_status.size();
   end

endmodule

[tb/sv/button_debounce_double_click_hold_tb.sv]
// ----------------------------------------------------------------------------
// button_debounce_double_click_hold_tb: testbench top for the debounced button
// Drives sampled button levels and clear strobes through the request channel,
// first a scripted click, double click and long press, then random press
// patterns over a range of debounce and window lengths, with random gaps
// and result back-pressure. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module button_debounce_double_click_hold_tb;
   import bdc_pkg::*;

   // Scripted sequence with a debounce of 2 and a window of 8 ticks: a first
   // click, a release, a double click cleared at once, then a long press
   // that lasts past the window and a final release.
   localparam int       SCRIPT_LEN   = 25;
   localparam bit [0:24] SCRIPT_LEVEL = 25'b0111000111100011111111110;
   localparam bit [0:24] SCRIPT_CLEAR = 25'b0001000001000000000000010;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_payload_type      rsp_payload;
   logic                 csr_write_en;
   csr_index_type        csr_index;
   logic [CFG_WIDTH-1:0] csr_wdata;

   int                   failures;
   int                   pending;
   bit                   no_idle;
   logic                 level_now;
   int                   run_left;

   button_debounce_double_click_hold dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   button_debounce_double_click_hold_checker status_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .failures     (failures),
      .pending      (pending)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Result back-pressure, switched off during the stretch without idling.
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 28);
   end

   // Offers one request after an optional random gap and waits for it to go.
   task automatic send_request(input logic level, input logic clear);
      req_payload_type sample;
      int              gap;

      gap = 0;
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 28) begin
            gap++;
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      sample.pressed_level = level;
      sample.clear_double  = clear;
      req_valid   <= 1'b1;
      req_payload <= sample;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Stops offering requests until every predicted result has been seen.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_lengths(input logic [CFG_WIDTH-1:0] debounce,
                                input logic [CFG_WIDTH-1:0] window);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DEBOUNCE_TICKS;
      csr_wdata    <= debounce;
      @(posedge clock);
      csr_index    <= CSR_WINDOW_TICKS;
      csr_wdata    <= window;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Random press patterns: mostly runs around the debounce length so that
   // clicks and double clicks settle, some long runs that can outlast the window
   // (both spans capped at 60) for long presses, and single-tick glitches as noise.
   task automatic run_random(input int debounce, input int window, input int count);
      int debounce_span;
      int window_span;
      int pick;

      drain_results();
      write_lengths(debounce[CFG_WIDTH-1:0], window[CFG_WIDTH-1:0]);
      debounce_span = (debounce == 0) ? 1 : ((debounce > 60) ? 60 : debounce);
      window_span   = (window == 0) ? 1 : ((window > 60) ? 60 : window);
      repeat (count) begin
         if (run_left == 0) begin
            level_now = ~level_now;
            pick      = $urandom_range(0, 99);
            if (pick < 15) begin
               run_left = 1;
            end else if (pick < 75) begin
               run_left = $urandom_range(1, debounce_span + 2);
            end else begin
               run_left = $urandom_range(debounce_span, debounce_span + window_span + 2);
            end
         end
         run_left--;
         send_request(level_now, $urandom_range(0, 3) == 0);
      end
   endtask

   // Hard limit on the run.
   initial begin
      #2000000;
      $display("FAIL button_debounce_double_click_hold");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_ready    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_DEBOUNCE_TICKS;
      csr_wdata    = '0;
      no_idle      = 1'b0;
      level_now    = 1'b0;
      run_left     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_lengths(16'd2, 16'd8);
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_request(SCRIPT_LEVEL[i], SCRIPT_CLEAR[i]);
      end
      level_now = SCRIPT_LEVEL[SCRIPT_LEN-1];

      run_random(1, 1, 60);
      run_random(0, 0, 40);
      no_idle = 1'b1;
      run_random(2, 6, 70);
      no_idle = 1'b0;
      run_random(3, 15, 80);
      run_random(65535, 65535, 20);
      run_random(50, 1000, 40);
      repeat (3) begin
         run_random($urandom_range(1, 6), $urandom_range(4, 30), 60);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("PASS button_debounce_double_click_hold");
      end else begin
         $display("FAIL button_debounce_double_click_hold");
      end
      $finish;
   end

endmodule
